[sv/wbsq_pkg.sv]
// ----------------------------------------------------------------------------
// Write buffer search queue package
// Shared codes, widths and controller command types for the write buffer.
// ----------------------------------------------------------------------------
package wbsq_pkg;

  // Width of the occupancy limit register.
  localparam int CFG_BITS = 5;

  // Reset value of the occupancy limit.
  localparam logic [CFG_BITS-1:0] MAX_ENTRIES_RESET = 5'd16;

  typedef logic [1:0] cmd_t;
  typedef logic [1:0] status_t;

  // Operation codes.
  localparam cmd_t CMD_PUSH   = 2'd0;
  localparam cmd_t CMD_POP    = 2'd1;
  localparam cmd_t CMD_REMOVE = 2'd2;
  localparam cmd_t CMD_SEARCH = 2'd3;

  // Result status codes.
  localparam status_t ST_DONE  = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;
  localparam status_t ST_MISS  = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // register the request and its match vector
    logic execute;  // apply the operation and load the result register
  } ctl_cmd_t;

endpackage

[sv/wbsq_req_if.sv]
// ----------------------------------------------------------------------------
// Write buffer request channel
// Valid/ready channel carrying one operation with its index and tag.
// ----------------------------------------------------------------------------
interface wbsq_req_if
  import wbsq_pkg::*;
#(
  parameter int INDEX_BITS = 16,
  parameter int TAG_BITS   = 32
);
  logic                  valid;
  logic                  ready;
  cmd_t                  cmd;
  logic [INDEX_BITS-1:0] line_index;
  logic [TAG_BITS-1:0]   line_tag;

  modport source (output valid, output cmd, output line_index, output line_tag,
                  input ready);
  modport sink   (input valid, input cmd, input line_index, input line_tag,
                  output ready);
endinterface

[sv/wbsq_rsp_if.sv]
// ----------------------------------------------------------------------------
// Write buffer result channel
// Valid/ready channel carrying the status, popped entry and occupancy.
// ----------------------------------------------------------------------------
interface wbsq_rsp_if
  import wbsq_pkg::*;
#(
  parameter int INDEX_BITS = 16,
  parameter int TAG_BITS   = 32,
  parameter int OCC_BITS   = 5
);
  logic                  valid;
  logic                  ready;
  status_t               status;
  logic [INDEX_BITS-1:0] popped_index;
  logic [TAG_BITS-1:0]   popped_tag;
  logic [OCC_BITS-1:0]   occupancy;

  modport source (output valid, output status, output popped_index,
                  output popped_tag, output occupancy, input ready);
  modport sink   (input valid, input status, input popped_index,
                  input popped_tag, input occupancy, output ready);
endinterface

[sv/wbsq_cfg_if.sv]
// ----------------------------------------------------------------------------
// Write buffer configuration channel
// Valid/ready write channel for the occupancy limit register.
// ----------------------------------------------------------------------------
interface wbsq_cfg_if
  import wbsq_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [CFG_BITS-1:0] max_entries;

  modport source (output valid, output max_entries, input ready);
  modport sink   (input valid, input max_entries, output ready);
endinterface

[sv/wbsq_ctrl.sv]
// ----------------------------------------------------------------------------
// Write buffer controller
// Two-state sequencer: capture a request, then execute it once the result
// register is free.
// ----------------------------------------------------------------------------
module wbsq_ctrl
  import wbsq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output ctl_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic out_free;

  // The result register may be refilled when empty or being taken.
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          cmd.execute = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.execute) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[sv/wbsq_datapath.sv]
// ----------------------------------------------------------------------------
// Write buffer datapath
// Entry row with parallel compare, close-up shifting, limit register and
// result register.
// ----------------------------------------------------------------------------
module wbsq_datapath
  import wbsq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int INDEX_BITS = 16,
  parameter int TAG_BITS   = 32,
  parameter int OCC_BITS   = 5
)(
  input  logic                  clk,
  input  logic                  rst,
  input  ctl_cmd_t              cmd,
  input  cmd_t                  in_cmd,
  input  logic [INDEX_BITS-1:0] in_index,
  input  logic [TAG_BITS-1:0]   in_tag,
  input  logic                  cfg_we,
  input  logic [CFG_BITS-1:0]   cfg_max,
  output status_t               status,
  output logic [INDEX_BITS-1:0] popped_index,
  output logic [TAG_BITS-1:0]   popped_tag,
  output logic [OCC_BITS-1:0]   occupancy
);

  localparam int CMP_BITS = (OCC_BITS > CFG_BITS) ? OCC_BITS : CFG_BITS;

  logic [INDEX_BITS-1:0] entry_index [DEPTH];
  logic [TAG_BITS-1:0]   entry_tag   [DEPTH];
  logic [OCC_BITS-1:0]   fill_count;
  logic [CFG_BITS-1:0]   max_entries;

  cmd_t                  op;
  logic [INDEX_BITS-1:0] op_index;
  logic [TAG_BITS-1:0]   op_tag;
  logic [DEPTH-1:0]      match;

  logic [DEPTH-1:0]      match_next;
  logic [DEPTH-1:0]      close_up;
  logic                  any_match;
  logic                  is_full;
  logic                  is_empty;
  logic                  do_push;
  logic                  do_shift;
  logic [OCC_BITS-1:0]   fill_count_next;
  status_t               status_next;

  // Parallel compare of the request against every held entry.
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      match_next[k] = (OCC_BITS'(k) < fill_count) && (entry_index[k] == in_index) &&
                      (entry_tag[k] == in_tag);
    end
  end

  // Entries at and above the newest match move down by one.
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      close_up[k] = ((match >> (k + 1)) == '0);
    end
  end

  assign any_match = |match;
  assign is_empty  = (fill_count == '0);
  assign is_full   = (CMP_BITS'(fill_count) >= CMP_BITS'(max_entries)) ||
                     (fill_count == OCC_BITS'(DEPTH));

  // Operation decode.
  always_comb begin
    do_push         = 1'b0;
    do_shift        = 1'b0;
    fill_count_next = fill_count;
    status_next     = ST_DONE;
    case (op)
      CMD_PUSH: begin
        if (is_full) begin
          status_next = ST_FULL;
        end else begin
          do_push         = 1'b1;
          fill_count_next = fill_count + OCC_BITS'(1);
        end
      end
      CMD_POP: begin
        if (is_empty) begin
          status_next = ST_EMPTY;
        end else begin
          do_shift        = 1'b1;
          fill_count_next = fill_count - OCC_BITS'(1);
        end
      end
      CMD_REMOVE: begin
        if (!any_match) begin
          status_next = ST_MISS;
        end else begin
          do_shift        = 1'b1;
          fill_count_next = fill_count - OCC_BITS'(1);
        end
      end
      default: begin
        status_next = any_match ? ST_DONE : ST_MISS;
      end
    endcase
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op       <= in_cmd;
      op_index <= in_index;
      op_tag   <= in_tag;
      match    <= match_next;
    end
  end

  // Entry row: append at the fill point or close up towards the head.
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      for (int k = 0; k < DEPTH; k++) begin
        if (do_push && (fill_count == OCC_BITS'(k))) begin
          entry_index[k] <= op_index;
          entry_tag[k]   <= op_tag;
        end else if (do_shift && ((op == CMD_POP) || close_up[k]) && (k < DEPTH - 1)) begin
          entry_index[k] <= entry_index[(k < DEPTH - 1) ? k + 1 : k];
          entry_tag[k]   <= entry_tag[(k < DEPTH - 1) ? k + 1 : k];
        end
      end
    end
  end

  // Fill count and occupancy limit.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count  <= '0;
      max_entries <= MAX_ENTRIES_RESET;
    end else begin
      if (cmd.execute) begin
        fill_count <= fill_count_next;
      end
      if (cfg_we) begin
        max_entries <= cfg_max;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      status    <= status_next;
      occupancy <= fill_count_next;
      if ((op == CMD_POP) && !is_empty) begin
        popped_index <= entry_index[0];
        popped_tag   <= entry_tag[0];
      end else begin
        popped_index <= '0;
        popped_tag   <= '0;
      end
    end
  end

endmodule

[sv/write_buffer_search_queue_top.sv]
// ----------------------------------------------------------------------------
// Write buffer search queue
// Bounded in-order buffer of (index, tag) entries with associative lookup.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request: cmd (push, pop oldest, remove newest match,
//   search), line_index and line_tag. rsp returns one result per request:
//   status, the popped entry (zero unless a pop succeeded) and occupancy.
//   cfg writes the occupancy limit; it is always ready and should only be
//   written while no request is outstanding.
// Timing:
//   A request is captured together with its compare against all entries in
//   parallel, and is then executed once the result register is free; the
//   result is registered. The controller's capture and execute steps take
//   no new request until the one held has been executed.
// Stalls:
//   A held result does not block acceptance of the next request; execution
//   of that request waits until the result register has been taken.
// Reset:
//   rst empties the buffer and sets the limit to 16. Entry storage is not
//   cleared; only entries below the fill count are ever read.
// ----------------------------------------------------------------------------
module write_buffer_search_queue_top
  import wbsq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int INDEX_BITS = 16,
  parameter int TAG_BITS   = 32
)(
  input logic      clk,
  input logic      rst,
  wbsq_req_if.sink req,
  wbsq_rsp_if.source rsp,
  wbsq_cfg_if.sink cfg
);

  // Occupancy width follows the depth.
  localparam int OCC_BITS = $clog2(DEPTH + 1);

  ctl_cmd_t ctl;

  // The limit register takes a write in any cycle.
  assign cfg.ready = 1'b1;

  // Sequencer.
  wbsq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (ctl)
  );

  // Entry storage, compare and result register.
  wbsq_datapath #(
    .DEPTH      (DEPTH),
    .INDEX_BITS (INDEX_BITS),
    .TAG_BITS   (TAG_BITS),
    .OCC_BITS   (OCC_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (ctl),
    .in_cmd       (req.cmd),
    .in_index     (req.line_index),
    .in_tag       (req.line_tag),
    .cfg_we       (cfg.valid),
    .cfg_max      (cfg.max_entries),
    .status       (rsp.status),
    .popped_index (rsp.popped_index),
    .popped_tag   (rsp.popped_tag),
    .occupancy    (rsp.occupancy)
  );

endmodule
